// ----- src/fsd_pkg.sv -----
`timescale 1ns / 1ps

package fsd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int ERR_W      = 10;
    localparam int EPOCH_W    = 3;
    localparam int THR_W      = 8;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [THR_W-1:0]   THRESHOLD_RST    = 8'd128;
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef logic signed [ERR_W-1:0] err_t;

    // one line store entry: frame tag plus stored correction
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        err_t               value;
    } line_word_t;

    typedef struct packed {
        logic               valid;
        logic               first_col;
        logic               last_col;
        logic               last_row;
        logic [EPOCH_W-1:0] epoch;
    } item_ctrl_t;

    typedef struct packed {
        logic       en;
        line_word_t word;
    } line_wr_t;

    function automatic err_t sat_err(input logic signed [12:0] x);
        if (x > 13'sd511)
            return 10'sd511;
        else if (x < -13'sd512)
            return -10'sd512;
        else
            return x[ERR_W-1:0];
    endfunction

    // (prod + 8) / 16 truncated toward zero
    function automatic logic signed [11:0] round_share(input logic signed [15:0] prod);
        logic signed [15:0] x;
        logic signed [15:0] q;
        x = prod + 16'sd8;
        q = x >>> 4;
        if (x[15] && (x[3:0] != 4'd0))
            q = q + 16'sd1;
        return 12'(q);
    endfunction

endpackage

// ----- src/fsd_stream_if.sv -----
`timescale 1ns / 1ps

interface fsd_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [fsd_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface fsd_dot_if;
    logic valid;
    logic ready;
    logic pixel_white;
    logic frame_end;

    modport source (output valid, output pixel_white, output frame_end, input ready);
    modport sink   (input valid, input pixel_white, input frame_end, output ready);
endinterface

// ----- src/fsd_line_store.sv -----
`timescale 1ns / 1ps

module fsd_line_store #(
    parameter int DEPTH = fsd_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(fsd_pkg::MAX_WIDTH_DEF)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output fsd_pkg::line_word_t  rd_word,
    input  fsd_pkg::line_wr_t    wr,
    input  logic [AW-1:0]        wr_addr,
    input  logic                 clr_en,
    input  logic [AW-1:0]        clr_addr
);

    fsd_pkg::line_word_t mem [DEPTH];
    fsd_pkg::line_word_t rd_reg;
    fsd_pkg::line_word_t byp_word_reg;
    logic                byp_reg;

    logic                wen;
    logic [AW-1:0]       waddr;
    fsd_pkg::line_word_t wdata;

    // clearing pass shares the single write port
    assign wen   = clr_en || wr.en;
    assign waddr = clr_en ? clr_addr : wr_addr;
    assign wdata = clr_en ? '0 : wr.word;

    always_ff @(posedge clk)
    begin
        if (wen)
            mem[waddr] <= wdata;
        if (rd_en)
        begin
            rd_reg       <= mem[rd_addr];
            byp_word_reg <= wdata;
        end
    end

    // write in the same cycle as the read forwards to the reader
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_reg <= 1'b0;
        else if (rd_en)
            byp_reg <= wen && (waddr == rd_addr);
    end

    assign rd_word = byp_reg ? byp_word_reg : rd_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_en && wr.en))
        else $error("line store clear collides with a diffusion write");

endmodule

// ----- src/fsd_front.sv -----
`timescale 1ns / 1ps

module fsd_front #(
    parameter int MAX_WIDTH  = fsd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fsd_pkg::MAX_HEIGHT_DEF,
    parameter int COL_W      = $clog2(fsd_pkg::MAX_WIDTH_DEF),
    parameter int ROW_W      = $clog2(fsd_pkg::MAX_HEIGHT_DEF)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    fsd_pixel_if.sink                       pixels,
    input  logic                            advance,
    output fsd_pkg::item_ctrl_t             item,
    output logic [fsd_pkg::PIX_W-1:0]       item_pixel,
    output logic [COL_W-1:0]                item_col,
    output logic [fsd_pkg::THR_W-1:0]       threshold,
    output logic                            rd_en,
    output logic [COL_W-1:0]                rd_addr,
    output logic                            clr_en,
    output logic [COL_W-1:0]                clr_addr
);

    localparam int CW = COL_W + 1;
    localparam int RW = ROW_W + 1;
    localparam logic [COL_W-1:0] CLR_LAST = COL_W'(MAX_WIDTH - 1);

    typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_DRAIN} state_t;

    state_t                        state_reg;
    logic [fsd_pkg::THR_W-1:0]     threshold_reg;
    logic [fsd_pkg::IMG_W_W-1:0]   width_reg;
    logic [fsd_pkg::IMG_H_W-1:0]   height_reg;
    logic [COL_W-1:0]              col_reg;
    logic [ROW_W-1:0]              row_reg;
    logic [fsd_pkg::EPOCH_W-1:0]   epoch_reg;
    logic [COL_W-1:0]              clr_addr_reg;

    logic                          s1_valid_reg;
    logic                          s1_first_reg;
    logic                          s1_last_col_reg;
    logic                          s1_last_row_reg;
    logic [fsd_pkg::EPOCH_W-1:0]   s1_epoch_reg;
    logic [fsd_pkg::PIX_W-1:0]     s1_pixel_reg;
    logic [COL_W-1:0]              s1_col_reg;

    logic [CW-1:0]                 w_eff;
    logic [RW-1:0]                 h_eff;
    logic                          last_col;
    logic                          last_row;
    logic                          accept;
    logic                          frame_done;

    always_comb
    begin
        if (width_reg < fsd_pkg::IMG_W_W'(2))
            w_eff = CW'(2);
        else if (width_reg > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);

        if (height_reg < fsd_pkg::IMG_H_W'(2))
            h_eff = RW'(2);
        else if (height_reg > MAX_HEIGHT)
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(height_reg);
    end

    assign last_col   = (CW'(col_reg) + CW'(1)) >= w_eff;
    assign last_row   = (RW'(row_reg) + RW'(1)) >= h_eff;
    assign accept     = pixels.valid && pixels.ready;
    assign frame_done = accept && last_col && last_row;

    assign pixels.ready = (state_reg == ST_RUN) && (!s1_valid_reg || advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            threshold_reg <= fsd_pkg::THRESHOLD_RST;
            width_reg     <= fsd_pkg::IMAGE_WIDTH_RST;
            height_reg    <= fsd_pkg::IMAGE_HEIGHT_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            epoch_reg     <= '0;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fsd_pkg::CFG_THRESHOLD:
                        threshold_reg <= cfg_wdata[fsd_pkg::THR_W-1:0];
                    fsd_pkg::CFG_IMAGE_WIDTH:
                        width_reg <= cfg_wdata[fsd_pkg::IMG_W_W-1:0];
                    fsd_pkg::CFG_IMAGE_HEIGHT:
                        height_reg <= cfg_wdata[fsd_pkg::IMG_H_W-1:0];
                    default:
                        ;
                endcase
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == CLR_LAST)
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_RUN;
                    end
                    else
                        clr_addr_reg <= clr_addr_reg + COL_W'(1);
                end
                ST_RUN:
                begin
                    // tag space runs out: wipe the store once the last pixel has left
                    if (frame_done && (epoch_reg == '1))
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (!s1_valid_reg)
                        state_reg <= ST_CLEAR;
                end
                default:
                    state_reg <= ST_CLEAR;
            endcase

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                if (last_col)
                begin
                    col_reg <= '0;
                    if (last_row)
                    begin
                        row_reg   <= '0;
                        epoch_reg <= epoch_reg + fsd_pkg::EPOCH_W'(1);
                    end
                    else
                        row_reg <= row_reg + ROW_W'(1);
                end
                else
                    col_reg <= col_reg + COL_W'(1);
            end
            else if (advance)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg    <= (col_reg == '0);
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            s1_epoch_reg    <= epoch_reg;
            s1_pixel_reg    <= pixels.pixel_in;
            s1_col_reg      <= col_reg;
        end
    end

    assign item.valid     = s1_valid_reg;
    assign item.first_col = s1_first_reg;
    assign item.last_col  = s1_last_col_reg;
    assign item.last_row  = s1_last_row_reg;
    assign item.epoch     = s1_epoch_reg;
    assign item_pixel     = s1_pixel_reg;
    assign item_col       = s1_col_reg;
    assign threshold      = threshold_reg;
    assign rd_en          = accept;
    assign rd_addr        = col_reg;
    assign clr_en         = (state_reg == ST_CLEAR);
    assign clr_addr       = clr_addr_reg;

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (col_reg == '0) && (row_reg == '0)
            && (epoch_reg == fsd_pkg::EPOCH_W'($past(epoch_reg) + 1'b1)))
        else $error("position or frame tag not advanced at end of frame");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s1_valid_reg)
        else $error("pixel in flight during line store clearing");

endmodule

// ----- src/fsd_diffuse.sv -----
`timescale 1ns / 1ps

module fsd_diffuse #(
    parameter int COL_W = $clog2(fsd_pkg::MAX_WIDTH_DEF)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [fsd_pkg::THR_W-1:0]  threshold,
    input  fsd_pkg::item_ctrl_t        item,
    input  logic [fsd_pkg::PIX_W-1:0]  item_pixel,
    input  logic [COL_W-1:0]           item_col,
    input  fsd_pkg::line_word_t        rd_word,
    output logic                       advance,
    output fsd_pkg::line_wr_t          wr,
    output logic [COL_W-1:0]           wr_addr,
    fsd_dot_if.source                  dots
);

    fsd_pkg::err_t      right_carry_reg;
    fsd_pkg::err_t      below_pending_reg;
    fsd_pkg::err_t      left_val_reg;      // latest value of the store entry just left behind
    logic [COL_W-1:0]   left_col_reg;
    logic               left_dirty_reg;    // that value is not in memory yet
    logic               out_valid_reg;
    logic               white_reg;
    logic               frame_end_reg;

    fsd_pkg::err_t      corr;
    logic signed [11:0] v;
    logic               white;
    logic signed [11:0] err;
    logic signed [15:0] err16;
    logic signed [11:0] s7;
    logic signed [11:0] s5;
    logic signed [11:0] s3;
    logic signed [11:0] s1;
    fsd_pkg::err_t      below_val;
    fsd_pkg::err_t      left_final;
    logic               fire;

    assign advance = !out_valid_reg || dots.ready;
    assign fire    = item.valid && advance;

    // entry from an earlier frame reads as zero
    assign corr = (rd_word.tag == item.epoch) ? rd_word.value : '0;

    always_comb
    begin
        v     = $signed({4'b0000, item_pixel}) + 12'(corr) + 12'(right_carry_reg);
        white = v >= $signed({4'b0000, threshold});
        err   = white ? (v - 12'sd255) : v;
        err16 = 16'(err);
        s7    = fsd_pkg::round_share(err16 * 16'sd7);
        s5    = fsd_pkg::round_share(err16 * 16'sd5);
        s3    = fsd_pkg::round_share(err16 * 16'sd3);
        s1    = fsd_pkg::round_share(err16);
        below_val  = fsd_pkg::sat_err(13'(below_pending_reg) + 13'(s5));
        left_final = fsd_pkg::sat_err(13'(left_val_reg) + 13'(s3));
    end

    always_comb
    begin
        wr.en         = 1'b0;
        wr.word.tag   = item.epoch;
        wr.word.value = left_val_reg;
        wr_addr       = left_col_reg;
        if (fire)
        begin
            if (!item.last_row && !item.first_col)
            begin
                wr.en         = 1'b1;
                wr.word.value = left_final;
                wr_addr       = item_col - COL_W'(1);
            end
            else if (left_dirty_reg)
                wr.en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_carry_reg   <= '0;
            below_pending_reg <= '0;
            left_dirty_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg   <= 1'b1;
            right_carry_reg <= item.last_col ? '0 : fsd_pkg::sat_err(13'(s7));
            left_dirty_reg  <= !item.last_row;
            if (item.last_col)
                below_pending_reg <= '0;
            else if (!item.last_row)
                below_pending_reg <= fsd_pkg::sat_err(13'(s1));
        end
        else if (dots.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            left_val_reg  <= item.last_row ? corr : below_val;
            left_col_reg  <= item_col;
            white_reg     <= white;
            frame_end_reg <= item.last_col && item.last_row;
        end
    end

    assign dots.valid       = out_valid_reg;
    assign dots.pixel_white = white_reg;
    assign dots.frame_end   = frame_end_reg;

    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.last_col) |=> (right_carry_reg == '0) && (below_pending_reg == '0))
        else $error("error carries survive the end of a row");

endmodule

// ----- src/floyd_steinberg_dither_core.sv -----
`timescale 1ns / 1ps

// Floyd-Steinberg error diffusion of an 8-bit gray raster stream.
// pixels: one gray pixel per transaction, raster order, valid/ready.
// dots:   one result per pixel, pixel_white plus frame_end on the last
//         pixel of the frame, valid/ready.
// Configuration: write threshold, image_width, image_height through
// cfg_we/cfg_index/cfg_wdata between pixels only when the pipe is empty.
// One pixel is accepted per clock while dots takes results and no sweep
// runs, set by the single input register, diffusion stage and result
// register around the one-read one-write line store. A stalled receiver
// holds the result register and then the input stage; outside a sweep,
// pixels.ready falls only when both are full.
// After reset, and again after every 8th frame end, the line store is
// swept once over entries 0 to MAX_WIDTH-1 with pixels.ready low (the
// sweep after a frame waits until its last pixel has left the input
// stage). Counters, carries and configuration registers reset at once.
module floyd_steinberg_dither_core #(
    parameter int MAX_WIDTH  = fsd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fsd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    fsd_pixel_if.sink                       pixels,
    fsd_dot_if.source                       dots
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    fsd_pkg::item_ctrl_t        item;
    logic [fsd_pkg::PIX_W-1:0]  item_pixel;
    logic [COL_W-1:0]           item_col;
    logic [fsd_pkg::THR_W-1:0]  threshold;
    logic                       advance;
    logic                       rd_en;
    logic [COL_W-1:0]           rd_addr;
    fsd_pkg::line_word_t        rd_word;
    fsd_pkg::line_wr_t          wr;
    logic [COL_W-1:0]           wr_addr;
    logic                       clr_en;
    logic [COL_W-1:0]           clr_addr;

    fsd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pixels     (pixels),
        .advance    (advance),
        .item       (item),
        .item_pixel (item_pixel),
        .item_col   (item_col),
        .threshold  (threshold),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .clr_en     (clr_en),
        .clr_addr   (clr_addr)
    );

    fsd_line_store #(
        .DEPTH    (MAX_WIDTH),
        .AW       (COL_W)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_word  (rd_word),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .clr_en   (clr_en),
        .clr_addr (clr_addr)
    );

    fsd_diffuse #(
        .COL_W      (COL_W)
    ) u_diffuse (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (threshold),
        .item       (item),
        .item_pixel (item_pixel),
        .item_col   (item_col),
        .rd_word    (rd_word),
        .advance    (advance),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .dots       (dots)
    );

endmodule
